// ----- rtl/wpsm_pkg.sv -----
// Shared types and constants for the wheel period speed meter.
package wpsm_pkg;

  localparam int NUM_SENSORS_DEF = 2;
  localparam int MAX_PERIODS_DEF = 64;
  localparam int TIMER_BITS_DEF  = 16;

  localparam int TIMER_IN_W = 16;
  localparam int SPEED_W    = 24;
  localparam int APB_DW     = 32;
  localparam int APB_AW     = 3;

  localparam logic [SPEED_W-1:0] SPEED_MAX       = 24'hFFFFFF;
  localparam logic [SPEED_W-1:0] NUMERATOR_RESET = 24'd409063;

  // Register word index
  localparam logic REG_SPEED_NUMERATOR = 1'b0;

  typedef enum logic [1:0] {
    OP_EDGE  = 2'd0,
    OP_QUERY = 2'd1,
    OP_ZERO  = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_AVG,
    ST_SPD,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic [1:0]            operation;
    logic                  wheel;
    logic [TIMER_IN_W-1:0] timer_count;
  } in_item_t;

  typedef struct packed {
    logic               wheel_out;
    logic [SPEED_W-1:0] speed;
    logic               had_periods;
  } out_item_t;

endpackage

// ----- rtl/wpsm_serial_div.sv -----
// Bit-serial restoring divider: one quotient bit per cycle.
module wpsm_serial_div #(
  parameter int DIV_W = wpsm_pkg::SPEED_W
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DIV_W-1:0] dividend,
  input  logic [DIV_W-1:0] divisor,
  output logic             done,
  output logic [DIV_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DIV_W + 1);

  logic [DIV_W-1:0] dvd_r, dvd_nxt;
  logic [DIV_W-1:0] dsr_r;
  logic [DIV_W-1:0] rem_r, rem_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic             done_r;

  logic [DIV_W:0] trial;
  logic [DIV_W:0] diff;
  logic           fits;

  // dividend shifts out at the top, quotient bits shift in at the bottom
  always_comb begin
    trial   = {rem_r, dvd_r[DIV_W-1]};
    diff    = trial - {1'b0, dsr_r};
    fits    = (trial >= {1'b0, dsr_r});
    rem_nxt = fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
    dvd_nxt = {dvd_r[DIV_W-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= (cnt_r == CNT_W'(1)) && !start;
      if (start) begin
        cnt_r <= CNT_W'(DIV_W);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      dsr_r <= divisor;
      rem_r <= '0;
    end else if (cnt_r != '0) begin
      dvd_r <= dvd_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = dvd_r;

endmodule

// ----- rtl/wpsm_wheel_bank.sv -----
// Per-wheel edge phase, start stamp, period sum and period count.
module wpsm_wheel_bank #(
  parameter int NUM_SENSORS = wpsm_pkg::NUM_SENSORS_DEF,
  parameter int MAX_PERIODS = wpsm_pkg::MAX_PERIODS_DEF,
  parameter int TIMER_BITS  = wpsm_pkg::TIMER_BITS_DEF,
  localparam int CNT_W = $clog2(MAX_PERIODS + 1),
  localparam int SUM_W = TIMER_BITS + CNT_W
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cmd_valid,
  input  logic [1:0]                      cmd_op,
  input  logic                            cmd_wheel,
  input  logic [wpsm_pkg::TIMER_IN_W-1:0] cmd_stamp,
  output logic                            cmd_ok,
  output logic [SUM_W-1:0]                rd_sum,
  output logic [CNT_W-1:0]                rd_count
);

  localparam int IDX_W = (NUM_SENSORS > 1) ? $clog2(NUM_SENSORS) : 1;

  logic                  awaiting_r [NUM_SENSORS];
  logic [TIMER_BITS-1:0] stamp_r    [NUM_SENSORS];
  logic [SUM_W-1:0]      sum_r      [NUM_SENSORS];
  logic [CNT_W-1:0]      cnt_r      [NUM_SENSORS];

  logic [IDX_W-1:0]      idx;
  logic [TIMER_BITS-1:0] stamp;
  logic [TIMER_BITS-1:0] period;

  assign idx      = IDX_W'(cmd_wheel);
  assign cmd_ok   = (32'(cmd_wheel) < NUM_SENSORS);
  assign stamp    = TIMER_BITS'(cmd_stamp);
  assign period   = stamp - stamp_r[idx];  // wraps modulo the timer width
  assign rd_sum   = sum_r[idx];
  assign rd_count = cnt_r[idx];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_SENSORS; i++) begin
        awaiting_r[i] <= 1'b0;
        sum_r[i]      <= '0;
        cnt_r[i]      <= '0;
      end
    end else if (cmd_valid && cmd_ok) begin
      case (cmd_op)
        wpsm_pkg::OP_EDGE: begin
          if (!awaiting_r[idx]) begin
            stamp_r[idx]    <= stamp;
            awaiting_r[idx] <= 1'b1;
          end else begin
            // count full: period dropped, phase still returns to start
            if (cnt_r[idx] < CNT_W'(MAX_PERIODS)) begin
              sum_r[idx] <= sum_r[idx] + SUM_W'(period);
              cnt_r[idx] <= cnt_r[idx] + CNT_W'(1);
            end
            awaiting_r[idx] <= 1'b0;
          end
        end
        wpsm_pkg::OP_QUERY: begin
          sum_r[idx] <= '0;
          cnt_r[idx] <= '0;
        end
        wpsm_pkg::OP_ZERO: begin
          awaiting_r[idx] <= 1'b0;
          sum_r[idx]      <= '0;
          cnt_r[idx]      <= '0;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ----- rtl/wheel_period_speed_meter_top.sv -----
// Wheel tachometer: edge stamping, period averaging and serial speed division.
// Edge and zero transactions do not leave idle; in_ready stays high for the next one.
// A query runs up to two passes through one bit-serial divider (average period,
// then numerator / average).
// The result sits in an output register; in_ready returns while it waits.
// Synchronous active-low reset clears the wheel phases, sums and counts and sets the numerator.
module wheel_period_speed_meter_top #(
  parameter int NUM_SENSORS = wpsm_pkg::NUM_SENSORS_DEF,
  parameter int MAX_PERIODS = wpsm_pkg::MAX_PERIODS_DEF,
  parameter int TIMER_BITS  = wpsm_pkg::TIMER_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  wpsm_pkg::in_item_t            in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output wpsm_pkg::out_item_t           out_data,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [wpsm_pkg::APB_AW-1:0]   cfg_paddr,
  input  logic [wpsm_pkg::APB_DW-1:0]   cfg_pwdata,
  output logic [wpsm_pkg::APB_DW-1:0]   cfg_prdata,
  output logic                          cfg_pready
);

  localparam int CNT_W = $clog2(MAX_PERIODS + 1);
  localparam int SUM_W = TIMER_BITS + CNT_W;
  localparam int DIV_W = (SUM_W > wpsm_pkg::SPEED_W) ? SUM_W : wpsm_pkg::SPEED_W;

  wpsm_pkg::state_t state_r, state_nxt;

  logic [wpsm_pkg::SPEED_W-1:0] num_r;
  logic                         wheel_r;
  logic [wpsm_pkg::SPEED_W-1:0] speed_r;
  logic                         had_r;
  logic                         out_valid_r;
  wpsm_pkg::out_item_t          out_data_r;

  logic             accept;
  logic             cmd_ok;
  logic [SUM_W-1:0] rd_sum;
  logic [CNT_W-1:0] rd_count;
  logic             query_go;

  logic             div_start;
  logic [DIV_W-1:0] div_dividend;
  logic [DIV_W-1:0] div_divisor;
  logic             div_done;
  logic [DIV_W-1:0] div_quotient;

  logic                         res_load;
  logic [wpsm_pkg::SPEED_W-1:0] res_speed;
  logic                         res_had;
  logic                         out_load;
  logic                         cfg_wr;

  assign accept   = in_valid && in_ready;
  assign query_go = accept && (in_data.operation == wpsm_pkg::OP_QUERY) && cmd_ok;

  wpsm_wheel_bank #(
    .NUM_SENSORS (NUM_SENSORS),
    .MAX_PERIODS (MAX_PERIODS),
    .TIMER_BITS  (TIMER_BITS)
  ) u_bank (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (accept),
    .cmd_op    (in_data.operation),
    .cmd_wheel (in_data.wheel),
    .cmd_stamp (in_data.timer_count),
    .cmd_ok    (cmd_ok),
    .rd_sum    (rd_sum),
    .rd_count  (rd_count)
  );

  wpsm_serial_div #(
    .DIV_W (DIV_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quotient)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      wpsm_pkg::ST_IDLE: begin
        if (query_go) begin
          state_nxt = (rd_sum != '0) ? wpsm_pkg::ST_AVG : wpsm_pkg::ST_OUT;
        end
      end
      wpsm_pkg::ST_AVG: begin
        if (div_done) begin
          state_nxt = (div_quotient != '0) ? wpsm_pkg::ST_SPD : wpsm_pkg::ST_OUT;
        end
      end
      wpsm_pkg::ST_SPD: begin
        if (div_done) begin
          state_nxt = wpsm_pkg::ST_OUT;
        end
      end
      wpsm_pkg::ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = wpsm_pkg::ST_IDLE;
        end
      end
      default: state_nxt = wpsm_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready     = 1'b0;
    div_start    = 1'b0;
    div_dividend = DIV_W'(rd_sum);
    div_divisor  = DIV_W'(rd_count);
    res_load     = 1'b0;
    res_speed    = '0;
    res_had      = 1'b0;
    out_load     = 1'b0;
    case (state_r)
      wpsm_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (query_go) begin
          // empty sum: speed 0, no periods
          div_start = (rd_sum != '0);
          res_load  = (rd_sum == '0);
        end
      end
      wpsm_pkg::ST_AVG: begin
        div_dividend = DIV_W'(num_r);
        div_divisor  = div_quotient;
        if (div_done) begin
          // average below one tick: speed 0 but periods were seen
          div_start = (div_quotient != '0);
          res_load  = (div_quotient == '0);
          res_had   = 1'b1;
        end
      end
      wpsm_pkg::ST_SPD: begin
        if (div_done) begin
          res_load  = 1'b1;
          res_had   = 1'b1;
          res_speed = (div_quotient > DIV_W'(wpsm_pkg::SPEED_MAX)) ?
                      wpsm_pkg::SPEED_MAX : div_quotient[wpsm_pkg::SPEED_W-1:0];
        end
      end
      wpsm_pkg::ST_OUT: begin
        out_load = !out_valid_r || out_ready;
      end
      default: begin
      end
    endcase
  end

  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= wpsm_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      num_r       <= wpsm_pkg::NUMERATOR_RESET;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_wr && (cfg_paddr[2] == wpsm_pkg::REG_SPEED_NUMERATOR)) begin
        num_r <= cfg_pwdata[wpsm_pkg::SPEED_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (query_go) begin
      wheel_r <= in_data.wheel;
    end
    if (res_load) begin
      speed_r <= res_speed;
      had_r   <= res_had;
    end
    if (out_load) begin
      out_data_r.wheel_out   <= wheel_r;
      out_data_r.speed       <= speed_r;
      out_data_r.had_periods <= had_r;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_data   = out_data_r;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == wpsm_pkg::REG_SPEED_NUMERATOR) ?
                      wpsm_pkg::APB_DW'(num_r) : '0;

endmodule

// ----- rtl/wpsm_checker.sv -----
// Port-level checks for the speed meter, bound to the top level.
module wpsm_port_checks (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input wpsm_pkg::in_item_t            in_data,
  input logic                          out_valid,
  input logic                          out_ready,
  input wpsm_pkg::out_item_t           out_data,
  input logic                          cfg_pready
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result dropped or changed while stalled");

  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_data.operation == wpsm_pkg::OP_QUERY) &&
    (in_data.wheel == 1'b0) |=> !in_ready)
    else $error("query did not occupy the divider");

  a_edge_single: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_data.operation == wpsm_pkg::OP_EDGE) |=> in_ready)
    else $error("edge transaction stalled the input");

  a_speed_had: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.speed != '0) |-> out_data.had_periods)
    else $error("nonzero speed without periods");

  a_pready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_pready)
    else $error("pready low");

endmodule

bind wheel_period_speed_meter_top wpsm_port_checks u_wpsm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .in_data    (in_data),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .out_data   (out_data),
  .cfg_pready (cfg_pready)
);
